>>> hw/rtl/drd_pkg.sv
package drd_pkg;

	localparam int FRAC_BITS   = 12;
	localparam int MAX_CLASSES = 128;
	localparam int DX_W        = 18;
	localparam int PX_W        = DX_W + 13;
	localparam int PW_W        = 16 + 13;
	localparam int PC_W        = 32;

	typedef logic signed [15:0] q_t;

	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH   = 3'd0,
		REG_IMAGE_HEIGHT  = 3'd1,
		REG_CONF_THRESH   = 3'd2,
		REG_OBJ_PRESENT   = 3'd3,
		REG_CLASS_COUNT   = 3'd4
	} reg_idx_t;

	localparam logic [11:0] IMAGE_WIDTH_RST  = 12'd640;
	localparam logic [11:0] IMAGE_HEIGHT_RST = 12'd480;
	localparam q_t          CONF_THRESH_RST  = 16'sd2048;
	localparam logic [7:0]  CLASS_COUNT_RST  = 8'd80;

	localparam q_t Q_ONE = q_t'(1 << FRAC_BITS);

	typedef struct packed {
		logic [11:0] image_width;
		logic [11:0] image_height;
		q_t          conf_thresh;
		logic        obj_present;
		logic [7:0]  class_count;
	} cfg_t;

	// finished row, box terms ready for scaling
	typedef struct packed {
		logic signed [DX_W-1:0] dx;
		logic signed [DX_W-1:0] dy;
		q_t                     w;
		q_t                     h;
		q_t                     best;
		q_t                     obj;
		logic [6:0]             cls;
		logic [15:0]            rows;
	} row_t;

	typedef struct packed {
		logic signed [PX_W-1:0] px;
		logic signed [PX_W-1:0] py;
		logic signed [PW_W-1:0] pw;
		logic signed [PW_W-1:0] ph;
		logic signed [PC_W-1:0] pconf;
		logic                   obj_pos;
		logic [6:0]             cls;
		logic [15:0]            rows;
	} prod_t;

endpackage

>>> hw/rtl/drd_elem_if.sv
interface drd_elem_if;
	import drd_pkg::*;

	logic valid;
	logic ready;
	q_t   value;
	logic frame_start;

	modport source (output valid, output value, output frame_start, input ready);
	modport sink   (input valid, input value, input frame_start, output ready);
endinterface

>>> hw/rtl/drd_det_if.sv
interface drd_det_if;
	import drd_pkg::*;

	logic        valid;
	logic        ready;
	logic        kept;
	logic [6:0]  class_id;
	q_t          confidence;
	logic [14:0] box_left;
	logic [14:0] box_top;
	q_t          box_width;
	q_t          box_height;
	logic [15:0] rows_seen;

	modport source (output valid, output kept, output class_id, output confidence,
		output box_left, output box_top, output box_width, output box_height,
		output rows_seen, input ready);
	modport sink (input valid, input kept, input class_id, input confidence,
		input box_left, input box_top, input box_width, input box_height,
		input rows_seen, output ready);
endinterface

>>> hw/rtl/drd_cfg_if.sv
interface drd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/detection_row_decoder.sv
// channel | dir | request carries
// elem    | in  | value (Q4.12), frame_start
// det     | out | kept, class_id, confidence, box_left/top/width/height, rows_seen
// cfg     | in  | index, data (register write, always ready)
//
// One row element per cycle; elements that do not end a row produce nothing.
// A row's result moves through registers from the edge that takes its last element:
// row capture on that edge, then the multiplier stage, then clamp and result register.
// Each stage holds its own valid; the input stalls only while a finished row
// cannot leave the capture stage.
// arst_n clears row state, counters, stage valids and restores register defaults.
module detection_row_decoder (
	input logic       clk,
	input logic       arst_n,
	drd_elem_if.sink  elem,
	drd_det_if.source det,
	drd_cfg_if.sink   cfg
);
	import drd_pkg::*;

	cfg_t  cfg_q;
	logic  row_valid, row_ready;
	row_t  row;
	logic  prod_valid, prod_ready;
	prod_t prod;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= IMAGE_WIDTH_RST;
			cfg_q.image_height <= IMAGE_HEIGHT_RST;
			cfg_q.conf_thresh  <= CONF_THRESH_RST;
			cfg_q.obj_present  <= 1'b0;
			cfg_q.class_count  <= CLASS_COUNT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg.data[11:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg.data[11:0];
				REG_CONF_THRESH:  cfg_q.conf_thresh  <= cfg.data;
				REG_OBJ_PRESENT:  cfg_q.obj_present  <= cfg.data[0];
				REG_CLASS_COUNT:  cfg_q.class_count  <= cfg.data[7:0];
				default: begin
				end
			endcase
		end
	end

	drd_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.elem      (elem),
		.cfg       (cfg_q),
		.row_valid (row_valid),
		.row       (row),
		.row_ready (row_ready)
	);

	drd_mult u_mult (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.row_valid  (row_valid),
		.row        (row),
		.row_ready  (row_ready),
		.prod_valid (prod_valid),
		.prod       (prod),
		.prod_ready (prod_ready)
	);

	drd_result u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.prod_valid (prod_valid),
		.prod       (prod),
		.prod_ready (prod_ready),
		.det        (det)
	);
endmodule

>>> hw/rtl/drd_accum.sv
module drd_accum (
	input  logic           clk,
	input  logic           arst_n,
	drd_elem_if.sink       elem,
	input  drd_pkg::cfg_t  cfg,
	output logic           row_valid,
	output drd_pkg::row_t  row,
	input  logic           row_ready
);
	import drd_pkg::*;

	logic [7:0]  pos_q;
	q_t          cx_q, cy_q, w_q, h_q, obj_q, best_q;
	logic [6:0]  cls_q;
	logic [15:0] rc_q;
	logic        row_v_q;
	row_t        row_q;

	logic [7:0]  classes;
	logic [7:0]  pos;
	logic [7:0]  start;
	logic [8:0]  last;
	logic [7:0]  idx;
	logic        is_class;
	logic        take_best;
	logic        row_end;
	logic        accept;
	logic [15:0] rc_base;
	logic [15:0] rc_next;
	q_t          best_n;
	logic [6:0]  cls_n;

	always_comb begin
		if (cfg.class_count == 8'd0)
			classes = 8'd1;
		else if (cfg.class_count > 8'(MAX_CLASSES))
			classes = 8'(MAX_CLASSES);
		else
			classes = cfg.class_count;
	end

	assign pos       = elem.frame_start ? 8'd0 : pos_q;
	assign start     = 8'd4 + {7'd0, cfg.obj_present};
	assign last      = {1'b0, start} + {1'b0, classes} - 9'd1;
	assign idx       = pos - start;
	assign is_class  = pos >= start;
	assign take_best = is_class && (idx == 8'd0 || elem.value > best_q);
	assign row_end   = {1'b0, pos} >= last;
	assign best_n    = take_best ? elem.value : best_q;
	assign cls_n     = take_best ? idx[6:0] : cls_q;
	assign rc_base   = elem.frame_start ? 16'd0 : rc_q;
	assign rc_next   = (row_end && rc_base != 16'hFFFF) ? rc_base + 16'd1 : rc_base;

	assign elem.ready = !row_v_q || row_ready;
	assign accept     = elem.valid && elem.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			cx_q   <= '0;
			cy_q   <= '0;
			w_q    <= '0;
			h_q    <= '0;
			obj_q  <= '0;
			best_q <= '0;
			cls_q  <= '0;
			rc_q   <= '0;
		end else if (accept) begin
			case (pos)
				8'd0: cx_q <= elem.value;
				8'd1: cy_q <= elem.value;
				8'd2: w_q  <= elem.value;
				8'd3: h_q  <= elem.value;
				default: begin
					if (!is_class)
						obj_q <= elem.value;
				end
			endcase
			best_q <= best_n;
			cls_q  <= cls_n;
			rc_q   <= rc_next;
			pos_q  <= row_end ? 8'd0 : pos + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_v_q <= 1'b0;
		end else if (elem.ready) begin
			row_v_q <= accept && row_end;
		end
	end

	// box values are settled by the time a row can end
	always_ff @(posedge clk) begin
		if (accept && row_end) begin
			row_q.dx   <= $signed({cx_q[15], cx_q, 1'b0}) - DX_W'(w_q);
			row_q.dy   <= $signed({cy_q[15], cy_q, 1'b0}) - DX_W'(h_q);
			row_q.w    <= w_q;
			row_q.h    <= h_q;
			row_q.best <= best_n;
			row_q.obj  <= cfg.obj_present ? obj_q : Q_ONE;
			row_q.cls  <= cls_n;
			row_q.rows <= rc_next;
		end
	end

	assign row_valid = row_v_q;
	assign row       = row_q;
endmodule

>>> hw/rtl/drd_mult.sv
module drd_mult (
	input  logic           clk,
	input  logic           arst_n,
	input  drd_pkg::cfg_t  cfg,
	input  logic           row_valid,
	input  drd_pkg::row_t  row,
	output logic           row_ready,
	output logic           prod_valid,
	output drd_pkg::prod_t prod,
	input  logic           prod_ready
);
	import drd_pkg::*;

	logic  v_s2;
	prod_t prod_s2;
	logic signed [12:0] w_px;
	logic signed [12:0] h_px;

	assign w_px = $signed({1'b0, cfg.image_width});
	assign h_px = $signed({1'b0, cfg.image_height});

	assign row_ready = !v_s2 || prod_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (row_ready) begin
			v_s2 <= row_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (row_ready && row_valid) begin
			prod_s2.px      <= row.dx * w_px;
			prod_s2.py      <= row.dy * h_px;
			prod_s2.pw      <= row.w * w_px;
			prod_s2.ph      <= row.h * h_px;
			prod_s2.pconf   <= row.best * row.obj;
			prod_s2.obj_pos <= row.obj > 16'sd0;
			prod_s2.cls     <= row.cls;
			prod_s2.rows    <= row.rows;
		end
	end

	assign prod_valid = v_s2;
	assign prod       = prod_s2;
endmodule

>>> hw/rtl/drd_result.sv
module drd_result (
	input  logic           clk,
	input  logic           arst_n,
	input  drd_pkg::cfg_t  cfg,
	input  logic           prod_valid,
	input  drd_pkg::prod_t prod,
	output logic           prod_ready,
	drd_det_if.source      det
);
	import drd_pkg::*;

	localparam logic [PW_W-1:0] TRUNC_BIAS = PW_W'((1 << FRAC_BITS) - 1);

	logic v_q;
	logic        kept_q;
	logic [6:0]  cls_q;
	q_t          conf_q;
	logic [14:0] left_q, top_q;
	q_t          bw_q, bh_q;
	logic [15:0] rows_q;

	logic [14:0] left, top;
	q_t          bw, bh, conf;

	// pixel corner: negative clamps to zero, so floor and trunc agree
	function automatic logic [14:0] corner(input logic signed [PX_W-1:0] p);
		logic signed [PX_W-1:0] s;
		s = p >>> (FRAC_BITS + 1);
		if (p < 0)
			corner = 15'd0;
		else if (s > PX_W'(32767))
			corner = 15'h7FFF;
		else
			corner = s[14:0];
	endfunction

	function automatic q_t extent(input logic signed [PW_W-1:0] p,
		input logic [11:0] dim, input logic [14:0] lo);
		logic signed [PW_W-1:0] b;
		logic signed [PW_W-1:0] t;
		logic signed [17:0]     lim;
		logic signed [PW_W-1:0] m;
		b   = (p < 0) ? p + $signed(TRUNC_BIAS) : p;
		t   = b >>> FRAC_BITS;
		lim = $signed({6'd0, dim}) - $signed({3'd0, lo});
		m   = (t > PW_W'(lim)) ? PW_W'(lim) : t;
		if (m > PW_W'(32767))
			extent = 16'sh7FFF;
		else if (m < -PW_W'(32768))
			extent = 16'sh8000;
		else
			extent = m[15:0];
	endfunction

	always_comb begin
		logic signed [PC_W-1:0] c;
		c = prod.pconf >>> FRAC_BITS;
		if (c > PC_W'(32767))
			conf = 16'sh7FFF;
		else if (c < -PC_W'(32768))
			conf = 16'sh8000;
		else
			conf = c[15:0];
	end

	assign left = corner(prod.px);
	assign top  = corner(prod.py);
	assign bw   = extent(prod.pw, cfg.image_width, left);
	assign bh   = extent(prod.ph, cfg.image_height, top);

	assign prod_ready = !v_q || det.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (prod_ready) begin
			v_q <= prod_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prod_ready && prod_valid) begin
			kept_q <= prod.obj_pos && (conf >= cfg.conf_thresh);
			cls_q  <= prod.cls;
			conf_q <= conf;
			left_q <= left;
			top_q  <= top;
			bw_q   <= bw;
			bh_q   <= bh;
			rows_q <= prod.rows;
		end
	end

	assign det.valid      = v_q;
	assign det.kept       = kept_q;
	assign det.class_id   = cls_q;
	assign det.confidence = conf_q;
	assign det.box_left   = left_q;
	assign det.box_top    = top_q;
	assign det.box_width  = bw_q;
	assign det.box_height = bh_q;
	assign det.rows_seen  = rows_q;
endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import drd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic        kept;
		logic [6:0]  class_id;
		q_t          confidence;
		logic [14:0] box_left;
		logic [14:0] box_top;
		q_t          box_width;
		q_t          box_height;
		logic [15:0] rows_seen;
	} det_t;

	class detection_scoreboard;
		logic [11:0] img_w;
		logic [11:0] img_h;
		q_t          conf_min;
		logic        obj_on;
		logic [7:0]  n_classes;

		logic [7:0]  position;
		q_t          cx, cy, bw, bh, objv, best;
		logic [6:0]  best_id;
		logic [15:0] row_count;

		det_t pending_detections[$];
		int   rows_predicted;
		int   failures;

		function new();
			img_w = IMAGE_WIDTH_RST;
			img_h = IMAGE_HEIGHT_RST;
			conf_min = CONF_THRESH_RST;
			obj_on = 1'b0;
			n_classes = CLASS_COUNT_RST;
			position = '0;
			cx = '0; cy = '0; bw = '0; bh = '0; objv = '0; best = '0;
			best_id = '0;
			row_count = '0;
			rows_predicted = 0;
			failures = 0;
		endfunction

		function int row_length();
			int n;
			n = n_classes;
			if (n < 1) n = 1;
			if (n > MAX_CLASSES) n = MAX_CLASSES;
			return 4 + int'(obj_on) + n;
		endfunction

		function int pending();
			return pending_detections.size();
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function void write_reg(reg_idx_t idx, logic [15:0] data);
			case (idx)
			REG_IMAGE_WIDTH: img_w = data[11:0];
			REG_IMAGE_HEIGHT: img_h = data[11:0];
			REG_CONF_THRESH: conf_min = q_t'(data);
			REG_OBJ_PRESENT: obj_on = data[0];
			REG_CLASS_COUNT: n_classes = data[7:0];
			default: ;
			endcase
		endfunction

		// advance the row state by one element, queue a detection at row end
		function void take_element(q_t v, logic fs);
			int     start, last, pos;
			longint obj, conf, wpx, hpx, left, top, iw, ih;
			bit     kept;
			det_t   d;
			start = 4 + int'(obj_on);
			last = row_length() - 1;
			if (fs) begin
				position = '0;
				row_count = '0;
			end
			pos = position;
			if (pos == 0) cx = v;
			else if (pos == 1) cy = v;
			else if (pos == 2) bw = v;
			else if (pos == 3) bh = v;
			else if (pos < start) objv = v;
			else if (pos == start || v > best) begin
				best = v;
				best_id = 7'(pos - start);
			end
			if (pos < last) begin
				position = 8'(pos + 1);
				return;
			end
			position = '0;
			if (row_count != 16'hFFFF) row_count++;
			rows_predicted++;

			obj = obj_on ? longint'(objv) : longint'(Q_ONE);
			conf = clip((longint'(best) * obj) >>> FRAC_BITS, -32768, 32767);
			wpx = longint'(img_w);
			hpx = longint'(img_h);
			// signed division truncates toward zero
			left = (2 * longint'(cx) * wpx - longint'(bw) * wpx) / (longint'(1) << (FRAC_BITS + 1));
			top = (2 * longint'(cy) * hpx - longint'(bh) * hpx) / (longint'(1) << (FRAC_BITS + 1));
			iw = (longint'(bw) * wpx) / (longint'(1) << FRAC_BITS);
			ih = (longint'(bh) * hpx) / (longint'(1) << FRAC_BITS);
			left = clip(left, 0, 32767);
			top = clip(top, 0, 32767);
			if (iw > wpx - left) iw = wpx - left;
			if (ih > hpx - top) ih = hpx - top;
			iw = clip(iw, -32768, 32767);
			ih = clip(ih, -32768, 32767);
			kept = (obj > 0) && (conf >= longint'(conf_min));

			d.kept = kept;
			d.class_id = best_id;
			d.confidence = q_t'(conf);
			d.box_left = 15'(left);
			d.box_top = 15'(top);
			d.box_width = q_t'(iw);
			d.box_height = q_t'(ih);
			d.rows_seen = row_count;
			pending_detections = {pending_detections, d};
		endfunction

		function string show(det_t d);
			return $sformatf("kept=%0d cls=%0d conf=%0d left=%0d top=%0d w=%0d h=%0d rows=%0d",
				d.kept, d.class_id, $signed(d.confidence), d.box_left, d.box_top,
				$signed(d.box_width), $signed(d.box_height), d.rows_seen);
		endfunction

		function void check_detection(det_t got);
			det_t  want;
			string diffs;
			if (pending_detections.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected detection: %s", show(got));
				return;
			end
			want = pending_detections.pop_front();
			diffs = "";
			if (got.kept !== want.kept) diffs = {diffs, " kept"};
			if (got.class_id !== want.class_id) diffs = {diffs, " class_id"};
			if (got.confidence !== want.confidence) diffs = {diffs, " confidence"};
			if (got.box_left !== want.box_left) diffs = {diffs, " box_left"};
			if (got.box_top !== want.box_top) diffs = {diffs, " box_top"};
			if (got.box_width !== want.box_width) diffs = {diffs, " box_width"};
			if (got.box_height !== want.box_height) diffs = {diffs, " box_height"};
			if (got.rows_seen !== want.rows_seen) diffs = {diffs, " rows_seen"};
			if (diffs != "") begin
				failures++;
				if (failures <= 10) begin
					$display("detection mismatch in%s", diffs);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		endfunction
	endclass

	bit   clk = 1'b0;
	logic arst_n;
	bit   no_idle = 1'b0;
	bit   hold_req = 1'b0;
	int   items_sent = 0;
	int   cycle_count = 0;

	detection_scoreboard sb;

	drd_elem_if elem();
	drd_det_if  det();
	drd_cfg_if  cfg();

	detection_row_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.elem(elem),
		.det(det),
		.cfg(cfg)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && det.valid && det.ready)
			sb.check_detection({det.kept, det.class_id, det.confidence, det.box_left,
				det.box_top, det.box_width, det.box_height, det.rows_seen});
	end

	// result side: random stalls, one long hold on request
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		det.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req <= 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				det.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				det.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 99) < 25) begin
				stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
					: $urandom_range(15, 80);
				det.ready <= 1'b0;
			end else begin
				det.ready <= 1'b1;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// valid stays high after the request so back-to-back elements need no toggle
	task automatic push_elem(q_t v, logic fs);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			elem.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		elem.valid <= 1'b1;
		elem.value <= v;
		elem.frame_start <= fs;
		@(posedge clk);
		while (!elem.ready) @(posedge clk);
		sb.take_element(v, fs);
		items_sent++;
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// unused upper data bits carry noise
	task automatic program_regs(logic [11:0] w, logic [11:0] h, q_t th, logic op,
			logic [7:0] cc);
		write_reg(REG_IMAGE_WIDTH, {4'($urandom), w});
		write_reg(REG_IMAGE_HEIGHT, {4'($urandom), h});
		write_reg(REG_CONF_THRESH, th);
		write_reg(REG_OBJ_PRESENT, {15'($urandom), op});
		write_reg(REG_CLASS_COUNT, {8'($urandom), cc});
		cfg.valid <= 1'b0;
	endtask

	// drop valid, wait out all detections plus the pipeline depth
	task automatic drain();
		elem.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_row(logic fs, logic broken);
		int len, cut, lo, hi, sel;
		bit box_full, score_full;
		q_t v;
		len = sb.row_length();
		cut = broken ? $urandom_range(1, len - 1) : len;
		box_full = ($urandom_range(0, 4) == 0);
		sel = $urandom_range(0, 3);
		score_full = (sel == 3);
		lo = (sel == 0) ? 0 : -1024;
		hi = (sel == 0) ? 7 : 8191;
		for (int i = 0; i < cut; i++) begin
			if (i < 4) begin
				v = box_full ? q_t'($urandom) : q_t'($urandom_range(0, 4096));
			end else if (i == 4 && sb.obj_on) begin
				sel = $urandom_range(0, 99);
				if (sel < 70) v = q_t'($urandom_range(1, 4096));
				else if (sel < 85) v = q_t'(-int'($urandom_range(0, 64)));
				else v = q_t'($urandom);
			end else begin
				v = score_full ? q_t'($urandom) : q_t'(int'($urandom_range(0, hi - lo)) + lo);
			end
			push_elem(v, fs && i == 0);
		end
	endtask

	initial begin
		int   phase, nrows, rows_mark;
		logic broken, restart;
		logic [11:0] w_set, h_set;
		q_t   th_set;
		logic [7:0] cc_set;

		sb = new();
		elem.valid <= 1'b0;
		elem.value <= '0;
		elem.frame_start <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_IMAGE_WIDTH;
		cfg.data <= '0;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// partial row at reset settings, then shrink the row mid-way
		push_elem(16'sd2048, 1'b1);
		push_elem(16'sd2048, 1'b0);
		push_elem(16'sd1024, 1'b0);
		push_elem(16'sd1024, 1'b0);
		push_elem(16'sd4096, 1'b0);
		drain();
		write_reg(REG_CLASS_COUNT, 16'd1);
		cfg.valid <= 1'b0;
		push_elem(16'sd8192, 1'b0);
		drain();

		program_regs(12'd4095, 12'd4095, 16'sh8000, 1'b1, 8'd2);
		// extremes, tied top scores
		push_elem(16'sh7FFF, 1'b1);
		push_elem(16'sh8000, 1'b0);
		push_elem(16'sh7FFF, 1'b0);
		push_elem(16'sh8000, 1'b0);
		push_elem(16'sh7FFF, 1'b0);
		push_elem(16'sh7FFF, 1'b0);
		push_elem(16'sh7FFF, 1'b0);
		// zero objectness rejects even with the lowest threshold
		push_elem(16'sd0, 1'b0);
		push_elem(16'sd0, 1'b0);
		push_elem(16'sd0, 1'b0);
		push_elem(16'sd0, 1'b0);
		push_elem(16'sd0, 1'b0);
		push_elem(16'sh8000, 1'b0);
		push_elem(16'sh8000, 1'b0);
		// frame start cuts a row short; box overflows the image
		push_elem(16'sh1234, 1'b0);
		push_elem(16'shEDCB, 1'b0);
		push_elem(16'sd4096, 1'b1);
		push_elem(16'sd4096, 1'b0);
		push_elem(16'sd8192, 1'b0);
		push_elem(16'sd8192, 1'b0);
		push_elem(16'sd1, 1'b0);
		push_elem(-16'sd5, 1'b0);
		push_elem(16'sd100, 1'b0);
		drain();

		items_sent = 0;
		rows_mark = sb.rows_predicted;
		phase = 0;
		while (items_sent < 700 || sb.rows_predicted - rows_mark < 60) begin
			case (phase)
			0: begin
				program_regs(IMAGE_WIDTH_RST, IMAGE_HEIGHT_RST, CONF_THRESH_RST, 1'b0,
					CLASS_COUNT_RST);
				nrows = 2;
			end
			1: begin
				program_regs(12'd1, 12'd1, 16'sh7FFF, 1'b1, 8'd255);
				nrows = 1;
			end
			2: begin
				program_regs(12'd0, 12'd0, 16'sh8000, 1'b0, 8'd0);
				nrows = 20;
			end
			default: begin
				w_set = ($urandom_range(0, 3) == 0) ? 12'hFFF : 12'($urandom_range(1, 4095));
				h_set = ($urandom_range(0, 3) == 0) ? 12'hFFF : 12'($urandom_range(1, 4095));
				case ($urandom_range(0, 5))
				0: th_set = q_t'($urandom);
				1: th_set = 16'sd0;
				default: th_set = q_t'($urandom_range(0, 6000));
				endcase
				cc_set = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(9, 16))
					: 8'($urandom_range(1, 8));
				program_regs(w_set, h_set, th_set, 1'($urandom), cc_set);
				nrows = (phase == 3) ? 40 : $urandom_range(6, 16);
			end
			endcase
			no_idle = (phase % 4 == 3);
			// hold the result side while elements keep coming
			if (phase == 3) hold_req <= 1'b1;
			restart = 1'b0;
			for (int r = 0; r < nrows; r++) begin
				broken = ($urandom_range(0, 9) == 0);
				send_row(r == 0 || restart || $urandom_range(0, 19) == 0, broken);
				restart = broken;
			end
			drain();
			phase++;
		end
		no_idle = 1'b0;

		drain();
		if (sb.failures == 0 && sb.pending() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
